// ----- rtl/core/ledd_pkg.sv -----
// Shared types, constants and patterns for the ladder encoder event decoder.
package ledd_pkg;

    // Field and storage widths
    localparam int DEF_SAMPLE_BITS = 10;
    localparam int THR_BITS        = 10;
    localparam int NUM_THR         = 5;
    localparam int CFG_IDX_BITS    = 3;
    localparam int LEVEL_BITS      = 3;
    localparam int EVENT_BITS      = 2;
    localparam int LONG_DEPTH      = 5;
    localparam int SHORT_DEPTH     = 3;

    typedef logic [LEVEL_BITS-1:0]              t_level;
    typedef logic [NUM_THR-1:0][THR_BITS-1:0]   t_thr_vec;
    // Index LONG_DEPTH-1 is the oldest entry, index 0 the newest
    typedef logic [LONG_DEPTH-1:0][LEVEL_BITS-1:0]  t_long_hist;
    typedef logic [SHORT_DEPTH-1:0][LEVEL_BITS-1:0] t_short_hist;

    typedef enum logic [EVENT_BITS-1:0] {
        EV_NONE  = 2'd0,
        EV_PLUS  = 2'd1,
        EV_MINUS = 2'd2,
        EV_PRESS = 2'd3
    } t_event;

    // Action codes of an input item
    localparam logic ACT_SAMPLE = 1'b0;
    localparam logic ACT_READ   = 1'b1;

    // Threshold reset values, register 0 last
    localparam t_thr_vec THR_RESET = {10'd200, 10'd300, 10'd500, 10'd600, 10'd700};

    // Level sequences, oldest entry in the leftmost position
    localparam t_long_hist  PAT_PLUS  = {3'd1, 3'd2, 3'd5, 3'd4, 3'd1};
    localparam t_long_hist  PAT_MINUS = {3'd1, 3'd4, 3'd5, 3'd2, 3'd1};
    localparam t_short_hist PAT_PRESS = {3'd1, 3'd3, 3'd1};

    // Classified item handed from the first stage to the tracker
    typedef struct packed {
        logic   read;
        t_level level;
    } t_cls_item;

    // One result item
    typedef struct packed {
        t_event event_code;
        t_level level;
        logic   event_detected;
    } t_result;

endpackage

// ----- rtl/core/ledd_in_if.sv -----
// Input channel: valid/ready handshake carrying action and ADC sample.
interface ledd_in_if #(
    parameter int SAMPLE_BITS = ledd_pkg::DEF_SAMPLE_BITS
);
    logic                   valid;
    logic                   ready;
    logic                   action;
    logic [SAMPLE_BITS-1:0] sample;

    modport source (output valid, output action, output sample, input ready);
    modport sink   (input valid, input action, input sample, output ready);
endinterface

// ----- rtl/core/ledd_out_if.sv -----
// Output channel: valid/ready handshake carrying one result item.
interface ledd_out_if;
    import ledd_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [EVENT_BITS-1:0] event_code;
    logic [LEVEL_BITS-1:0] level;
    logic                  event_detected;

    modport source (output valid, output event_code, output level, output event_detected,
                    input ready);
    modport sink   (input valid, input event_code, input level, input event_detected,
                    output ready);
endinterface

// ----- rtl/core/ledd_thresholds.sv -----
// Threshold register file written through the configuration port.
module ledd_thresholds (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [ledd_pkg::CFG_IDX_BITS-1:0]    i_cfg_idx,
    input  logic [ledd_pkg::THR_BITS-1:0]        i_cfg_data,
    output ledd_pkg::t_thr_vec                   o_thr
);
    import ledd_pkg::*;

    t_thr_vec r_thr;
    t_thr_vec n_thr;

    // Write the addressed register, drop writes beyond the list
    always_comb begin
        n_thr = r_thr;
        if (i_cfg_we && (i_cfg_idx < CFG_IDX_BITS'(NUM_THR))) begin
            n_thr[i_cfg_idx] = i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THR_RESET;
        end else begin
            r_thr <= n_thr;
        end
    end

    assign o_thr = r_thr;

endmodule

// ----- rtl/core/ledd_classify.sv -----
// Input stage: sort the sample into a ladder level and register the item.
module ledd_classify #(
    parameter int SAMPLE_BITS = ledd_pkg::DEF_SAMPLE_BITS
) (
    input  logic                     i_clk,
    input  logic                     i_load,
    input  logic                     i_action,
    input  logic [SAMPLE_BITS-1:0]   i_sample,
    input  ledd_pkg::t_thr_vec       i_thr,
    output ledd_pkg::t_cls_item      o_item
);
    import ledd_pkg::*;

    localparam int CMP_BITS = (SAMPLE_BITS > THR_BITS) ? SAMPLE_BITS : THR_BITS;

    logic [CMP_BITS-1:0] sample_ext;
    t_level              level;
    t_cls_item           n_item;
    t_cls_item           r_item;

    assign sample_ext = CMP_BITS'(i_sample);

    // First threshold exceeded decides; scan from the last so the lowest index wins
    always_comb begin
        level = LEVEL_BITS'(NUM_THR + 1);
        for (int k = NUM_THR - 1; k >= 0; k--) begin
            if (sample_ext > CMP_BITS'(i_thr[k])) begin
                level = LEVEL_BITS'(k + 1);
            end
        end
        n_item.read  = (i_action == ACT_READ);
        n_item.level = level;
    end

    // Hold the item until the stage advances
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_item <= n_item;
        end
    end

    assign o_item = r_item;

endmodule

// ----- rtl/core/ledd_tracker.sv -----
// Level history, pattern match, latched event and result register.
module ledd_tracker (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_adv,
    input  ledd_pkg::t_cls_item  i_item,
    output ledd_pkg::t_result    o_result
);
    import ledd_pkg::*;

    t_level     r_prev_level, n_prev_level;
    t_long_hist r_long, n_long;
    t_event     r_pending, n_pending;
    t_result    r_res, n_res;
    t_event     code;

    // The short history is always the newest entries of the long one
    always_comb begin
        n_prev_level = r_prev_level;
        n_long       = r_long;
        n_pending    = r_pending;
        code         = EV_NONE;
        n_res        = r_res;
        if (i_adv) begin
            if (i_item.read) begin
                // Return the latched event and clear it
                n_res.event_code     = r_pending;
                n_res.level          = r_prev_level;
                n_res.event_detected = 1'b0;
                n_pending            = EV_NONE;
            end else begin
                if (i_item.level != r_prev_level) begin
                    n_long = {r_long[LONG_DEPTH-2:0], i_item.level};
                    priority if (n_long == PAT_PLUS) begin
                        code = EV_PLUS;
                    end else if (n_long == PAT_MINUS) begin
                        code = EV_MINUS;
                    end else if (n_long[SHORT_DEPTH-1:0] == PAT_PRESS) begin
                        code = EV_PRESS;
                    end else begin
                        code = EV_NONE;
                    end
                    if (code != EV_NONE) begin
                        n_pending = code;
                    end
                    n_prev_level = i_item.level;
                end
                n_res.event_code     = code;
                n_res.level          = i_item.level;
                n_res.event_detected = (code != EV_NONE);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_level <= '0;
            r_long       <= '0;
            r_pending    <= EV_NONE;
        end else begin
            r_prev_level <= n_prev_level;
            r_long       <= n_long;
            r_pending    <= n_pending;
        end
    end

    // Result payload needs no reset
    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    assign o_result = r_res;

endmodule

// ----- rtl/core/ladder_encoder_event_decoder_core.sv -----
// Top level of the ladder encoder event decoder.
//
//  channel  | dir | handshake          | payload
//  ---------+-----+--------------------+-------------------------------------
//  i_in     | in  | valid / ready      | action, sample[SAMPLE_BITS-1:0]
//  o_out    | out | valid / ready      | event_code[1:0], level[2:0], event_detected
//  i_cfg_*  | in  | write enable only  | i_cfg_idx[2:0], i_cfg_data[9:0]
//
// Two register stages: the input stage classifies the sample against the
// thresholds, the tracker updates history and event and registers the result.
// One item per clock unless the output stalls; the result register drives o_out.
// A stalled output holds the result; the input stage keeps accepting while it is
// empty or the output register is free or being drained in the same cycle.
// Reset (synchronous, active low) restores thresholds and clears all history.
module ladder_encoder_event_decoder_core #(
    parameter int SAMPLE_BITS = ledd_pkg::DEF_SAMPLE_BITS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    ledd_in_if.sink                            i_in,
    ledd_out_if.source                         o_out,
    input  logic                               i_cfg_we,
    input  logic [ledd_pkg::CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [ledd_pkg::THR_BITS-1:0]      i_cfg_data
);
    import ledd_pkg::*;

    logic      r_s1_valid;
    logic      r_out_valid;
    logic      out_free;
    logic      in_ready;
    logic      load;
    logic      adv;
    t_thr_vec  thr;
    t_cls_item item;
    t_result   result;

    // Pipeline flow control; hold off input transfers during reset
    assign out_free = !r_out_valid || o_out.ready;
    assign in_ready = i_rst_n && (!r_s1_valid || out_free);
    assign load     = i_in.valid && in_ready;
    assign adv      = r_s1_valid && out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_ready) begin
                r_s1_valid <= i_in.valid;
            end
            if (out_free) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    ledd_thresholds u_thresholds (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_thr      (thr)
    );

    ledd_classify #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_classify (
        .i_clk    (i_clk),
        .i_load   (load),
        .i_action (i_in.action),
        .i_sample (i_in.sample),
        .i_thr    (thr),
        .o_item   (item)
    );

    ledd_tracker u_tracker (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (adv),
        .i_item   (item),
        .o_result (result)
    );

    // Drive the channels
    assign i_in.ready           = in_ready;
    assign o_out.valid          = r_out_valid;
    assign o_out.event_code     = EVENT_BITS'(result.event_code);
    assign o_out.level          = result.level;
    assign o_out.event_detected = result.event_detected;

endmodule
